/* design/odo_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the odometry core.
// Used by odo_mul, odo_div and differential_drive_odometry_core; no dependencies.
package odo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_N = 24;
    localparam int STEP_W = $clog2(ATAN_N + 1);
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int DIV_N_W = 56;
    localparam int DIV_D_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_MPP  = 8'd0,
        REG_RIGHT_MPP = 8'd1,
        REG_ANGLE     = 8'd2,
        REG_PEN       = 8'd3,
        REG_MIN_INT   = 8'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_CORDIC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } fsm_t;

    typedef enum logic [3:0] {
        OP_TL,
        OP_TR,
        OP_TH,
        OP_XC,
        OP_YS,
        OP_PX,
        OP_PY,
        OP_VL,
        OP_VR
    } op_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* design/odo_mul.sv */
// Bit-serial shift-and-add multiplier on magnitudes, one multiplier bit per cycle.
// Depends on odo_pkg for the request type and widths.
module odo_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  odo_pkg::mul_req_t             req,
    output logic                          done,
    output logic [odo_pkg::MUL_A_W-1:0]   prod
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          neg_reg, neg_next;
    logic [odo_pkg::MUL_A_W-1:0]   a_reg, a_next;
    logic [odo_pkg::MUL_A_W-1:0]   acc_reg, acc_next;
    logic [odo_pkg::MUL_A_W-1:0]   prod_reg, prod_next;
    logic [odo_pkg::MUL_B_W-1:0]   b_reg, b_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.neg;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            // The pass ends as soon as no multiplier bits are left.
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                prod_next = neg_reg ? (~acc_reg + 64'd1) : acc_reg;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[odo_pkg::MUL_A_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[odo_pkg::MUL_B_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

/* design/odo_div.sv */
// Restoring divider, one quotient bit per cycle, with signed 32-bit saturation.
// Depends on odo_pkg for the request type and widths.
module odo_div (
    input  logic              clk,
    input  logic              rst_n,
    input  odo_pkg::div_req_t req,
    output logic              done,
    output logic [31:0]       quot
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic                            neg_reg, neg_next;
    logic [odo_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [odo_pkg::DIV_D_W-1:0]     rem_reg, rem_next;
    logic [odo_pkg::DIV_D_W-1:0]     den_reg, den_next;
    logic [odo_pkg::DIV_N_W-1:0]     quo_reg, quo_next;
    logic [31:0]                     res_reg, res_next;
    logic [odo_pkg::DIV_D_W:0]       shifted;
    logic [odo_pkg::DIV_D_W:0]       diff;
    logic                            ge;
    logic                            too_big;

    assign shifted = {rem_reg, quo_reg[odo_pkg::DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};
    // Negative results may reach -2^31; positive ones stop at 2^31 - 1.
    assign too_big = neg_reg ? ((|quo_reg[odo_pkg::DIV_N_W-1:32]) ||
                                (quo_reg[31] && (|quo_reg[30:0])))
                             : (|quo_reg[odo_pkg::DIV_N_W-1:31]);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.neg;
            cnt_next  = odo_pkg::DIV_CNT_W'(odo_pkg::DIV_N_W);
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (too_big)
                begin
                    res_next = neg_reg ? 32'h80000000 : 32'h7FFFFFFF;
                end
                else
                begin
                    res_next = neg_reg ? (~quo_reg[31:0] + 32'd1) : quo_reg[31:0];
                end
            end
            else
            begin
                rem_next = ge ? diff[odo_pkg::DIV_D_W-1:0] : shifted[odo_pkg::DIV_D_W-1:0];
                quo_next = {quo_reg[odo_pkg::DIV_N_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign quot = res_reg;

endmodule

/* design/differential_drive_odometry_core.sv */
// Top level of the differential-drive wheel odometry core: sequencer, pose state,
// CORDIC and output register. Depends on odo_pkg, odo_mul and odo_div.
//
//  Channel  Handshake                Payload
//  -------  -----------------------  ---------------------------------------------
//  in       in_valid / in_stall      total_left, total_right, time_ms
//  out      out_valid / out_stall    updated, pos_x, pos_y, heading, pen_x, pen_y,
//                                    speed_left, speed_right
//  cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item is worked on at a time. A baseline item or one that comes before the
// minimum interval goes from S_IDLE straight to S_OUT and then into the output register.
// An item that updates the pose takes three multiplier passes for the wheel travel
// and heading, the CORDIC rotation, four passes for position and pen point, then a
// multiplier pass and a divider pass for each wheel speed: nine bit-serial
// multiplier passes and two divider passes, before the output register is loaded.
// Reset clears the pose, the baseline flag and the handshakes and loads the
// register defaults. A stalled result waits in the output register while the
// next item may already be accepted and worked on.
module differential_drive_odometry_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [31:0]               total_left,
    input  logic signed [31:0]               total_right,
    input  logic [31:0]                      time_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             updated,
    output logic signed [31:0]               pos_x,
    output logic signed [31:0]               pos_y,
    output logic [15:0]                      heading,
    output logic signed [31:0]               pen_x,
    output logic signed [31:0]               pen_y,
    output logic signed [31:0]               speed_left,
    output logic signed [31:0]               speed_right,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [odo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [23:0]        lmpp_reg;
    logic [23:0]        rmpp_reg;
    logic [23:0]        apm_reg;
    logic [20:0]        pen_reg;
    logic [15:0]        minint_reg;

    // Sequencer.
    odo_pkg::fsm_t      state_reg, state_next;
    odo_pkg::op_t       op_reg, op_next;

    // Odometry state kept between items.
    logic               started_reg, started_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic [31:0]        last_left_reg, last_left_next;
    logic [31:0]        last_right_reg, last_right_next;
    logic [31:0]        x_acc_reg, x_acc_next;
    logic [31:0]        y_acc_reg, y_acc_next;
    logic [15:0]        theta_reg, theta_next;

    // Working values of one item.
    logic               upd_reg, upd_next;
    logic [31:0]        dlt_l_reg, dlt_l_next;
    logic [31:0]        dlt_r_reg, dlt_r_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic [47:0]        dl_reg, dl_next;
    logic [47:0]        dr_reg, dr_next;
    logic signed [odo_pkg::CW-1:0] cx_reg, cx_next;
    logic signed [odo_pkg::CW-1:0] cy_reg, cy_next;
    logic signed [odo_pkg::CW-1:0] cz_reg, cz_next;
    logic signed [odo_pkg::CW-1:0] cs_reg, cs_next;
    logic signed [odo_pkg::CW-1:0] sn_reg, sn_next;
    logic [odo_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic               flip_reg, flip_next;
    logic [31:0]        penx_reg, penx_next;
    logic [31:0]        peny_reg, peny_next;
    logic [31:0]        spdl_reg, spdl_next;
    logic [31:0]        spdr_reg, spdr_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               updated_reg, updated_next;
    logic [31:0]        pos_x_reg, pos_x_next;
    logic [31:0]        pos_y_reg, pos_y_next;
    logic [15:0]        heading_reg, heading_next;
    logic [31:0]        pen_x_reg, pen_x_next;
    logic [31:0]        pen_y_reg, pen_y_next;
    logic [31:0]        spd_l_reg, spd_l_next;
    logic [31:0]        spd_r_reg, spd_r_next;

    // Shared arithmetic units.
    odo_pkg::mul_req_t  mul_req;
    logic               mul_done;
    logic [63:0]        mul_prod;
    odo_pkg::div_req_t  div_req;
    logic               div_done;
    logic [31:0]        div_quot;

    logic               in_take;
    logic               out_load;
    logic [31:0]        elapsed_now;
    logic [31:0]        min_eff;
    logic               too_soon;
    logic [48:0]        diff_w;
    logic [48:0]        sum_w;
    logic [47:0]        ctr_w;
    logic [63:0]        opa;
    logic [odo_pkg::CW-1:0] opb;
    logic [63:0]        mag_a;
    logic [odo_pkg::CW-1:0] mag_b;
    logic [63:0]        rnd_c;
    logic [63:0]        rnd;
    logic [15:0]        th_new;
    logic [31:0]        ang;
    logic signed [odo_pkg::CW-1:0] dx;
    logic signed [odo_pkg::CW-1:0] dy;
    logic [odo_pkg::CW-1:0] atan_w;
    logic               cordic_end;

    odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    odo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Configuration writes are always taken; the user must send them to an idle block.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmpp_reg   <= 24'd65536;
            rmpp_reg   <= 24'd65536;
            apm_reg    <= 24'd65536;
            pen_reg    <= 21'd0;
            minint_reg <= 16'd50;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                odo_pkg::REG_LEFT_MPP:  lmpp_reg   <= cfg_data[23:0];
                odo_pkg::REG_RIGHT_MPP: rmpp_reg   <= cfg_data[23:0];
                odo_pkg::REG_ANGLE:     apm_reg    <= cfg_data[23:0];
                odo_pkg::REG_PEN:       pen_reg    <= cfg_data[20:0];
                odo_pkg::REG_MIN_INT:   minint_reg <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    // Elapsed time wraps with the millisecond counter; an interval of zero acts as one.
    assign elapsed_now = time_ms - last_time_reg;
    assign min_eff     = (minint_reg == 16'd0) ? 32'd1 : {16'd0, minint_reg};
    assign too_soon    = elapsed_now < min_eff;

    assign in_take    = in_valid && !in_stall;
    assign out_load   = (state_reg == odo_pkg::S_OUT) && (!out_valid_reg || !out_stall);
    assign cordic_end = cnt_reg == odo_pkg::STEP_W'(odo_pkg::CORDIC_STEPS);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            odo_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!started_reg || too_soon)
                    begin
                        state_next = odo_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = odo_pkg::S_MUL_GO;
                        op_next    = odo_pkg::OP_TL;
                    end
                end
            end
            odo_pkg::S_MUL_GO:
            begin
                state_next = odo_pkg::S_MUL_WAIT;
            end
            odo_pkg::S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = odo_pkg::S_MUL_GO;
                    case (op_reg)
                        odo_pkg::OP_TL: op_next = odo_pkg::OP_TR;
                        odo_pkg::OP_TR: op_next = odo_pkg::OP_TH;
                        odo_pkg::OP_TH: state_next = odo_pkg::S_CORDIC;
                        odo_pkg::OP_XC: op_next = odo_pkg::OP_YS;
                        odo_pkg::OP_YS: op_next = odo_pkg::OP_PX;
                        odo_pkg::OP_PX: op_next = odo_pkg::OP_PY;
                        odo_pkg::OP_PY: op_next = odo_pkg::OP_VL;
                        default:        state_next = odo_pkg::S_DIV_GO;
                    endcase
                end
            end
            odo_pkg::S_CORDIC:
            begin
                if (cordic_end)
                begin
                    state_next = odo_pkg::S_MUL_GO;
                    op_next    = odo_pkg::OP_XC;
                end
            end
            odo_pkg::S_DIV_GO:
            begin
                state_next = odo_pkg::S_DIV_WAIT;
            end
            odo_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (op_reg == odo_pkg::OP_VL)
                    begin
                        state_next = odo_pkg::S_MUL_GO;
                        op_next    = odo_pkg::OP_VR;
                    end
                    else
                    begin
                        state_next = odo_pkg::S_OUT;
                    end
                end
            end
            odo_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    state_next = odo_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = odo_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input handshake.
    always_comb
    begin
        in_stall = (state_reg != odo_pkg::S_IDLE);
    end

    // Operand selection for the multiplier. Operands go in as magnitudes, the
    // product sign is restored inside the unit, except for the speed products.
    assign diff_w = {dr_reg[47], dr_reg} - {dl_reg[47], dl_reg};
    assign sum_w  = {dl_reg[47], dl_reg} + {dr_reg[47], dr_reg};
    assign ctr_w  = sum_w[48:1];

    always_comb
    begin
        case (op_reg)
            odo_pkg::OP_TL:
            begin
                opa = {{32{dlt_l_reg[31]}}, dlt_l_reg};
                opb = {10'd0, lmpp_reg};
            end
            odo_pkg::OP_TR:
            begin
                opa = {{32{dlt_r_reg[31]}}, dlt_r_reg};
                opb = {10'd0, rmpp_reg};
            end
            odo_pkg::OP_TH:
            begin
                opa = {{15{diff_w[48]}}, diff_w};
                opb = {10'd0, apm_reg};
            end
            odo_pkg::OP_XC:
            begin
                opa = {{16{ctr_w[47]}}, ctr_w};
                opb = cs_reg;
            end
            odo_pkg::OP_YS:
            begin
                opa = {{16{ctr_w[47]}}, ctr_w};
                opb = sn_reg;
            end
            odo_pkg::OP_PX:
            begin
                opa = {{43{pen_reg[20]}}, pen_reg};
                opb = cs_reg;
            end
            odo_pkg::OP_PY:
            begin
                opa = {{43{pen_reg[20]}}, pen_reg};
                opb = sn_reg;
            end
            odo_pkg::OP_VL:
            begin
                opa = {{16{dl_reg[47]}}, dl_reg};
                opb = 34'd100;
            end
            default:
            begin
                opa = {{16{dr_reg[47]}}, dr_reg};
                opb = 34'd100;
            end
        endcase
    end

    assign mag_a = opa[63] ? (~opa + 64'd1) : opa;
    assign mag_b = opb[odo_pkg::CW-1] ? (~opb + 34'd1) : opb;

    // The speed products stay magnitudes; the divider applies their sign.
    always_comb
    begin
        mul_req.start = (state_reg == odo_pkg::S_MUL_GO);
        mul_req.neg   = ((op_reg == odo_pkg::OP_VL) || (op_reg == odo_pkg::OP_VR)) ? 1'b0 :
                        (opa[63] ^ opb[odo_pkg::CW-1]);
        mul_req.a     = mag_a;
        mul_req.b     = mag_b[31:0];
    end

    // The speed dividend is the magnitude of travel times 100 left by the multiplier.
    always_comb
    begin
        div_req.start = (state_reg == odo_pkg::S_DIV_GO);
        div_req.neg   = (op_reg == odo_pkg::OP_VL) ? dl_reg[47] : dr_reg[47];
        div_req.num   = mul_prod[odo_pkg::DIV_N_W-1:0];
        div_req.den   = elapsed_reg;
    end

    // Rounding constant: half of the scale that the product is taken down by.
    always_comb
    begin
        case (op_reg)
            odo_pkg::OP_TL: rnd_c = 64'h80;
            odo_pkg::OP_TR: rnd_c = 64'h80;
            odo_pkg::OP_TH: rnd_c = 64'h800000;
            default:        rnd_c = 64'h20000000;
        endcase
    end

    assign rnd    = mul_prod + rnd_c;
    assign th_new = theta_reg + rnd[39:24];
    // Fold the angle into the right half-plane; a folded result is negated afterwards.
    assign ang    = {th_new[14], th_new[14:0], 16'd0};

    assign dx     = cy_reg >>> cnt_reg;
    assign dy     = cx_reg >>> cnt_reg;
    assign atan_w = {2'b00, odo_pkg::atan_val(cnt_reg)};

    // Datapath next values.
    always_comb
    begin
        started_next    = started_reg;
        last_time_next  = last_time_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        x_acc_next      = x_acc_reg;
        y_acc_next      = y_acc_reg;
        theta_next      = theta_reg;
        upd_next        = upd_reg;
        dlt_l_next      = dlt_l_reg;
        dlt_r_next      = dlt_r_reg;
        elapsed_next    = elapsed_reg;
        dl_next         = dl_reg;
        dr_next         = dr_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        cs_next         = cs_reg;
        sn_next         = sn_reg;
        cnt_next        = cnt_reg;
        flip_next       = flip_reg;
        penx_next       = penx_reg;
        peny_next       = peny_reg;
        spdl_next       = spdl_reg;
        spdr_next       = spdr_reg;

        if (in_take)
        begin
            upd_next = 1'b0;
            if (!started_reg)
            begin
                // The first item only records the baseline.
                started_next    = 1'b1;
                last_time_next  = time_ms;
                last_left_next  = total_left;
                last_right_next = total_right;
            end
            else if (!too_soon)
            begin
                upd_next        = 1'b1;
                dlt_l_next      = total_left - last_left_reg;
                dlt_r_next      = total_right - last_right_reg;
                elapsed_next    = elapsed_now;
                last_time_next  = time_ms;
                last_left_next  = total_left;
                last_right_next = total_right;
            end
        end

        if ((state_reg == odo_pkg::S_MUL_WAIT) && mul_done)
        begin
            case (op_reg)
                odo_pkg::OP_TL: dl_next = rnd[55:8];
                odo_pkg::OP_TR: dr_next = rnd[55:8];
                odo_pkg::OP_TH:
                begin
                    theta_next = th_new;
                    flip_next  = th_new[15] ^ th_new[14];
                    cx_next    = odo_pkg::CORDIC_X0;
                    cy_next    = '0;
                    cz_next    = {{2{ang[31]}}, ang};
                    cnt_next   = '0;
                end
                odo_pkg::OP_XC: x_acc_next = x_acc_reg + rnd[61:30];
                odo_pkg::OP_YS: y_acc_next = y_acc_reg + rnd[61:30];
                odo_pkg::OP_PX: penx_next  = x_acc_reg + rnd[61:30];
                odo_pkg::OP_PY: peny_next  = y_acc_reg + rnd[61:30];
                default:        ;
            endcase
        end

        if (state_reg == odo_pkg::S_CORDIC)
        begin
            if (cordic_end)
            begin
                cs_next = flip_reg ? -cx_reg : cx_reg;
                sn_next = flip_reg ? -cy_reg : cy_reg;
            end
            else
            begin
                // One rotation step: turn toward a residual angle of zero.
                if (!cz_reg[odo_pkg::CW-1])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - $signed(atan_w);
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + $signed(atan_w);
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if ((state_reg == odo_pkg::S_DIV_WAIT) && div_done)
        begin
            if (op_reg == odo_pkg::OP_VL)
            begin
                spdl_next = div_quot;
            end
            else
            begin
                spdr_next = div_quot;
            end
        end
    end

    // Output register: fields are zero when the item made no new pose.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        updated_next   = updated_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        heading_next   = heading_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        spd_l_next     = spd_l_reg;
        spd_r_next     = spd_r_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            updated_next   = upd_reg;
            pos_x_next     = upd_reg ? x_acc_reg : 32'd0;
            pos_y_next     = upd_reg ? y_acc_reg : 32'd0;
            heading_next   = upd_reg ? theta_reg : 16'd0;
            pen_x_next     = upd_reg ? penx_reg : 32'd0;
            pen_y_next     = upd_reg ? peny_reg : 32'd0;
            spd_l_next     = upd_reg ? spdl_reg : 32'd0;
            spd_r_next     = upd_reg ? spdr_reg : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= odo_pkg::S_IDLE;
            op_reg         <= odo_pkg::OP_TL;
            started_reg    <= 1'b0;
            last_time_reg  <= '0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
            theta_reg      <= '0;
            upd_reg        <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            started_reg    <= started_next;
            last_time_reg  <= last_time_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            x_acc_reg      <= x_acc_next;
            y_acc_reg      <= y_acc_next;
            theta_reg      <= theta_next;
            upd_reg        <= upd_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dlt_l_reg   <= dlt_l_next;
        dlt_r_reg   <= dlt_r_next;
        elapsed_reg <= elapsed_next;
        dl_reg      <= dl_next;
        dr_reg      <= dr_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        cs_reg      <= cs_next;
        sn_reg      <= sn_next;
        flip_reg    <= flip_next;
        penx_reg    <= penx_next;
        peny_reg    <= peny_next;
        spdl_reg    <= spdl_next;
        spdr_reg    <= spdr_next;
        updated_reg <= updated_next;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        heading_reg <= heading_next;
        pen_x_reg   <= pen_x_next;
        pen_y_reg   <= pen_y_next;
        spd_l_reg   <= spd_l_next;
        spd_r_reg   <= spd_r_next;
    end

    assign out_valid   = out_valid_reg;
    assign updated     = updated_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign heading     = heading_reg;
    assign pen_x       = pen_x_reg;
    assign pen_y       = pen_y_reg;
    assign speed_left  = spd_l_reg;
    assign speed_right = spd_r_reg;

`ifndef NO_ASSERTIONS
    a_no_pose_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !updated) |-> (pos_x == 32'd0 && heading == 16'd0 &&
                                     speed_left == 32'd0 && pen_y == 32'd0))
        else $error("result without a pose carries nonzero fields");

    a_pose_after_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && updated) |-> started_reg)
        else $error("pose reported before a baseline was taken");

    a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while one is in work");

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == odo_pkg::S_MUL_WAIT))
        else $error("multiplier finished while the sequencer was not waiting");

    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == odo_pkg::S_CORDIC) |->
            (cnt_reg <= odo_pkg::STEP_W'(odo_pkg::CORDIC_STEPS)))
        else $error("CORDIC step counter ran past its last step");
`endif

endmodule
